// ===== hdl/brlm_pkg.sv =====
// shared types and constants for the block rms level meter
package brlm_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int SUM_W         = 40;
  localparam int ROOT_W        = SUM_W / 2;
  localparam int RMS_W         = 16;
  localparam int FIB_W         = 10;
  localparam int MAX_FRAMES_DF = 512;

  localparam int S_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((RMS_W + FIB_W + 7) / 8) * 8;

  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_SQRT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accum;
    logic start_div;
    logic div_step;
    logic sqrt_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

// ===== hdl/brlm_ctrl.sv =====
// controller: accumulate, divide, square root and result hand-off sequencing
module brlm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  input  logic              m_tready,
  input  brlm_pkg::status_t stat,
  output logic              s_tready,
  output brlm_pkg::cmd_t    cmd,
  output brlm_pkg::state_t  state
);

  brlm_pkg::state_t             state_next;
  logic [brlm_pkg::STEP_W-1:0]  step;
  logic [brlm_pkg::STEP_W-1:0]  step_next;
  logic                         out_free;

  assign out_free = !stat.out_busy || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brlm_pkg::ST_ACCUM;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      brlm_pkg::ST_ACCUM: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accum = 1'b1;
          if (s_tlast) begin
            cmd.start_div = 1'b1;
            step_next     = '0;
            state_next    = brlm_pkg::ST_DIVIDE;
          end
        end
      end
      brlm_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (step == brlm_pkg::STEP_W'(brlm_pkg::DIV_STEPS - 1)) begin
          step_next  = '0;
          state_next = brlm_pkg::ST_SQRT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      brlm_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step == brlm_pkg::STEP_W'(brlm_pkg::SQRT_STEPS - 1)) begin
          step_next  = '0;
          state_next = brlm_pkg::ST_DONE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      brlm_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = brlm_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_next = brlm_pkg::ST_ACCUM;
      end
    endcase
  end

endmodule

// ===== hdl/brlm_datapath.sv =====
// datapath: square accumulator, restoring divider, digit square root, output register
module brlm_datapath #(
  parameter int MAX_FRAMES = brlm_pkg::MAX_FRAMES_DF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic signed [brlm_pkg::SAMPLE_W-1:0] left_sample,
  input  brlm_pkg::cmd_t                   cmd,
  input  logic                             m_tready,
  output logic                             m_tvalid,
  output logic [brlm_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                             m_tuser,
  output brlm_pkg::status_t                stat
);

  localparam int CntW  = $clog2(MAX_FRAMES + 1);
  localparam int SumW  = brlm_pkg::SUM_W;
  localparam int RootW = brlm_pkg::ROOT_W;

  // running block state
  logic [SumW-1:0]  square_sum;
  logic [CntW-1:0]  frame_count;
  logic             overflow_seen;

  // block-end work registers
  logic [SumW-1:0]    qr;
  logic [CntW-1:0]    divisor;
  logic [CntW-1:0]    drem;
  logic               res_ovf;
  logic [RootW+1:0]   srem;
  logic [RootW-1:0]   root;

  // output register
  logic [brlm_pkg::RMS_W-1:0] rms_level;
  logic [brlm_pkg::FIB_W-1:0] frames_in_block;
  logic                       frames_dropped;

  logic signed [2*brlm_pkg::SAMPLE_W-1:0] square;
  logic [SumW-1:0]  sum_next;
  logic [CntW-1:0]  count_next;
  logic             ovf_next;
  logic [CntW:0]    div_cur;
  logic             qbit;
  logic [RootW+3:0] s_cur;
  logic [RootW+3:0] s_trial;
  logic             rbit;

  assign square = left_sample * left_sample;

  always_comb begin
    if (frame_count < CntW'(MAX_FRAMES)) begin
      sum_next   = square_sum + SumW'($unsigned(square));
      count_next = frame_count + 1'b1;
      ovf_next   = overflow_seen;
    end else begin
      sum_next   = square_sum;
      count_next = frame_count;
      ovf_next   = 1'b1;
    end
  end

  // one quotient bit per cycle, zero divisor gives a zero quotient
  assign div_cur = {drem, qr[SumW-1]};
  assign qbit    = (div_cur >= {1'b0, divisor}) && (divisor != '0);

  // one root bit per cycle from the next two bits of the mean
  assign s_cur   = {srem, qr[SumW-1 -: 2]};
  assign s_trial = {2'b00, root, 2'b01};
  assign rbit    = s_cur >= s_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum    <= '0;
      frame_count   <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.accum) begin
      if (cmd.start_div) begin
        square_sum    <= '0;
        frame_count   <= '0;
        overflow_seen <= 1'b0;
      end else begin
        square_sum    <= sum_next;
        frame_count   <= count_next;
        overflow_seen <= ovf_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      qr      <= sum_next;
      divisor <= count_next;
      res_ovf <= ovf_next;
      drem    <= '0;
      srem    <= '0;
      root    <= '0;
    end else if (cmd.div_step) begin
      qr <= {qr[SumW-2:0], qbit};
      if (qbit) begin
        drem <= CntW'(div_cur - {1'b0, divisor});
      end else begin
        drem <= CntW'(div_cur);
      end
    end else if (cmd.sqrt_step) begin
      qr   <= {qr[SumW-3:0], 2'b00};
      root <= {root[RootW-2:0], rbit};
      if (rbit) begin
        srem <= (RootW + 2)'(s_cur - s_trial);
      end else begin
        srem <= (RootW + 2)'(s_cur);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rms_level       <= root[brlm_pkg::RMS_W-1:0];
      frames_in_block <= brlm_pkg::FIB_W'(divisor);
      frames_dropped  <= res_ovf;
    end
  end

  assign m_tdata = brlm_pkg::M_TDATA_W'({frames_in_block, rms_level});
  assign m_tuser = frames_dropped;
  assign stat.out_busy = m_tvalid;

endmodule

// ===== hdl/block_rms_level_meter_core.sv =====
// top level of the block rms level meter
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata[15:0] left_sample, s_tlast last_frame
//  m_       out  m_tvalid/m_tready  m_tdata[15:0] rms_level, [25:16] frames_in_block,
//                                   m_tuser frames_dropped
//
// a sample without tlast is taken while in the accumulate state, one transfer per cycle sustained
// a sample with tlast starts the block end: the divide state, the square root state
// and the done state that loads the output register; s_tready is low throughout,
// and the done state waits while an earlier result has not yet left on m_tready
// the output register lets the next block start while a result waits on m_tready
// rst is synchronous and clears the accumulator, the sequencer and m_tvalid
module block_rms_level_meter_core #(
  parameter int MAX_FRAMES = brlm_pkg::MAX_FRAMES_DF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [brlm_pkg::S_TDATA_W-1:0]    s_tdata,   // left_sample
  input  logic                              s_tlast,   // last_frame
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [brlm_pkg::M_TDATA_W-1:0]    m_tdata,   // rms_level, frames_in_block
  output logic                              m_tuser    // frames_dropped
);

  brlm_pkg::cmd_t    cmd;
  brlm_pkg::status_t stat;
  brlm_pkg::state_t  state;

  brlm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .m_tready (m_tready),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd),
    .state    (state)
  );

  brlm_datapath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .left_sample ($signed(s_tdata[brlm_pkg::SAMPLE_W-1:0])),
    .cmd         (cmd),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .stat        (stat)
  );

  // a closing transfer always starts the divider
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (state == brlm_pkg::ST_DIVIDE))
    else $error("block end did not start the divider");

  // a fresh result only comes out of the done state
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == brlm_pkg::ST_DONE))
    else $error("result raised outside the done state");

  // no input transfer while the block end is being worked out
  assert property (@(posedge clk) disable iff (rst)
    (state != brlm_pkg::ST_ACCUM) |-> !s_tready)
    else $error("input ready during block-end work");

endmodule

// ===== bench/rms_result_checker.sv =====
`timescale 1ns / 100ps
// checker for the block rms level meter: predicts block results and compares them
module rms_result_checker #(
  parameter int MAX_FRAMES = brlm_pkg::MAX_FRAMES_DF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [brlm_pkg::S_TDATA_W-1:0] s_tdata,   // left_sample
  input  logic                           s_tlast,   // last_frame
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [brlm_pkg::M_TDATA_W-1:0] m_tdata,   // rms_level, frames_in_block
  input  logic                           m_tuser,   // frames_dropped
  output int                             mismatches,
  output int                             pending,
  output int                             samples_seen,
  output int                             results_seen,
  output int                             drop_results
);

  typedef struct packed {
    logic [brlm_pkg::RMS_W-1:0] rms;
    logic [brlm_pkg::FIB_W-1:0] frames;
    logic                       dropped;
  } block_result_t;

  block_result_t              rms_expected_q[$];
  logic [brlm_pkg::SUM_W-1:0] energy_sum;
  int unsigned                frames_taken;
  logic                       frames_lost;

  // bit by bit search for the largest root whose square still fits under v
  function automatic logic [brlm_pkg::RMS_W-1:0] floor_root(
    input logic [brlm_pkg::SUM_W-1:0] v
  );
    logic [brlm_pkg::ROOT_W-1:0] r;
    logic [brlm_pkg::ROOT_W-1:0] t;
    logic [brlm_pkg::SUM_W:0]    sq;
    r = '0;
    for (int b = brlm_pkg::ROOT_W - 1; b >= 0; b--) begin
      t = r | (brlm_pkg::ROOT_W'(1) << b);
      sq = (brlm_pkg::SUM_W + 1)'(t) * (brlm_pkg::SUM_W + 1)'(t);
      if (sq <= (brlm_pkg::SUM_W + 1)'(v)) r = t;
    end
    return r[brlm_pkg::RMS_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    block_result_t              want;
    block_result_t              got;
    logic [15:0]                mag;
    logic [brlm_pkg::SUM_W-1:0] mean;
    if (rst) begin
      rms_expected_q.delete();
      energy_sum   = '0;
      frames_taken = 0;
      frames_lost  = 1'b0;
      mismatches   <= 0;
      pending      <= 0;
      samples_seen <= 0;
      results_seen <= 0;
      drop_results <= 0;
    end else begin
      // result side first: a result always belongs to an earlier block
      if (m_tvalid && m_tready) begin
        got.rms     = m_tdata[brlm_pkg::RMS_W-1:0];
        got.frames  = m_tdata[brlm_pkg::RMS_W +: brlm_pkg::FIB_W];
        got.dropped = m_tuser;
        results_seen <= results_seen + 1;
        if (got.dropped) drop_results <= drop_results + 1;
        if (rms_expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] result with no block pending: rms %0d frames %0d dropped %0b",
                     $time, got.rms, got.frames, got.dropped);
          mismatches <= mismatches + 1;
        end else begin
          want = rms_expected_q.pop_front();
          if (got != want) begin
            if (mismatches < 10)
              $display("[%0t] rms/frames/dropped expected %0d/%0d/%0b, got %0d/%0d/%0b",
                       $time, want.rms, want.frames, want.dropped,
                       got.rms, got.frames, got.dropped);
            mismatches <= mismatches + 1;
          end
        end
      end

      if (s_tvalid && s_tready) begin
        samples_seen <= samples_seen + 1;
        mag = s_tdata[15] ? (~s_tdata[15:0] + 16'd1) : s_tdata[15:0];
        if (frames_taken < MAX_FRAMES) begin
          energy_sum   = energy_sum + brlm_pkg::SUM_W'(mag) * brlm_pkg::SUM_W'(mag);
          frames_taken = frames_taken + 1;
        end else begin
          frames_lost = 1'b1;
        end
        if (s_tlast) begin
          mean = (frames_taken != 0) ? energy_sum / frames_taken : '0;
          want.rms     = floor_root(mean);
          want.frames  = brlm_pkg::FIB_W'(frames_taken);
          want.dropped = frames_lost;
          rms_expected_q.push_back(want);
          energy_sum   = '0;
          frames_taken = 0;
          frames_lost  = 1'b0;
        end
      end

      pending <= rms_expected_q.size();
    end
  end

endmodule

// ===== bench/tb_block_rms_level_meter_core.sv =====
`timescale 1ns / 100ps
// testbench top for the block rms level meter: clock, reset, stimulus and verdict
module tb_block_rms_level_meter_core;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SAMPLE_TARGET = 1600;
  localparam int BLOCK_TARGET  = 40;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [brlm_pkg::S_TDATA_W-1:0] s_tdata;   // left_sample
  logic                           s_tlast;   // last_frame
  logic                           m_tvalid;
  logic                           m_tready;
  logic [brlm_pkg::M_TDATA_W-1:0] m_tdata;   // rms_level, frames_in_block
  logic                           m_tuser;   // frames_dropped

  int mismatches;
  int pending;
  int samples_seen;
  int results_seen;
  int drop_results;
  int cycles;
  int samples_sent;
  bit steady;
  int hold;

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    m_tready = 1'b0;
    cycles   = 0;
    steady   = 1'b0;
    hold     = 0;
  end

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  block_rms_level_meter_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  rms_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .mismatches   (mismatches),
    .pending      (pending),
    .samples_seen (samples_seen),
    .results_seen (results_seen),
    .drop_results (drop_results)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side back-pressure: runs of ready, short stalls and the odd long one
  always @(posedge clk) begin
    if (!rst) begin
      if (hold > 0) begin
        hold <= hold - 1;
      end else begin
        case ($urandom_range(99)) inside
          [0:49]:  begin m_tready <= 1'b1; hold <= $urandom_range(30, 1); end
          [50:87]: begin m_tready <= 1'b0; hold <= $urandom_range(3); end
          default: begin m_tready <= 1'b0; hold <= $urandom_range(80, 20); end
        endcase
      end
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (steady || p < 55) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // style 0 full range, 1 quiet, 2 extremes, 3 loud with random sign, else a mix
  function automatic logic [15:0] pick_sample(input int style);
    logic [15:0] v;
    case (style)
      0: v = 16'($urandom_range(65535));
      1: v = 16'($urandom_range(127)) - 16'd64;
      2: begin
        case ($urandom_range(5))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h8001;
          3: v = 16'hFFFF;
          4: v = 16'h0001;
          default: v = 16'h0000;
        endcase
      end
      3: begin
        v = 16'($urandom_range(32767, 24000));
        if ($urandom_range(1)) v = -v;
      end
      default: v = pick_sample($urandom_range(3));
    endcase
    return v;
  endfunction

  task automatic send_sample(input logic [15:0] smp, input logic last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  task automatic send_block(input int len, input int style);
    for (int i = 0; i < len; i++)
      send_sample(pick_sample(style), i == len - 1);
  endtask

  initial begin : stimulus
    int blk;
    int len;
    int p;
    samples_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single frame blocks at the extremes
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0001, 1'b1);
    // mixed block with both extremes and alternating bit patterns
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8001, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h0000, 1'b1);
    // equal magnitudes of both signs
    send_sample(16'h0003, 1'b0);
    send_sample(16'hFFFD, 1'b0);
    send_sample(16'h0004, 1'b0);
    send_sample(16'hFFFC, 1'b1);

    blk = 0;
    while (samples_sent < SAMPLE_TARGET || blk < BLOCK_TARGET) begin
      steady = ($urandom_range(7) == 0);
      p = $urandom_range(99);
      if (blk == 4)
        len = brlm_pkg::MAX_FRAMES_DF;                         // exactly full, nothing dropped
      else if (blk == 12)
        len = brlm_pkg::MAX_FRAMES_DF + $urandom_range(24, 1); // runs past the block capacity
      else if (p < 85)
        len = $urandom_range(16, 1);
      else
        len = $urandom_range(100, 17);
      send_block(len, $urandom_range(4));
      blk++;
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("sent %0d samples in %0d random and 7 directed blocks", samples_seen, blk);
    $display("checked %0d block results, %0d of them with dropped frames",
             results_seen, drop_results);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (pending != 0) $display("%0d expected results never arrived", pending);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
